// ----- design/tps_pkg.sv -----
// Shared types, constants and helpers for the tridiagonal Poisson solver.
`default_nettype none
package tps_pkg;

  // Widths fixed by the item fields
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PIDX_W  = 7;
  // Divider numerator width: magnitude of (sum * 2^24) plus half divisor
  localparam int unsigned DIV_W   = 58;
  localparam int unsigned DIVC_W  = 6;
  localparam int unsigned WIDE_W  = 60;

  localparam logic [DATA_W-1:0] STEP_SQ_RESET = 32'd4294967;
  localparam logic [DATA_W-1:0] TWO_Q24       = 32'h0200_0000;
  localparam logic [DIV_W-1:0]  ONE_SQ_Q48    = 58'h1_0000_0000_0000;

  // Register index of step_squared
  localparam logic CFG_IDX_STEP_SQ = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIAG_GO,
    ST_DIAG_WAIT,
    ST_RHS_GO,
    ST_RHS_WAIT,
    ST_STORE,
    ST_READ,
    ST_BACK_GO,
    ST_BACK_WAIT,
    ST_EMIT
  } tps_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              clipped;
  } sat_t;

  // Clip a wide signed value to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > $signed(WIDE_W'(64'sh7FFF_FFFF))) begin
      r.value   = 32'h7FFF_FFFF;
      r.clipped = 1'b1;
    end else if (v < -$signed(WIDE_W'(64'sh8000_0000))) begin
      r.value   = 32'h8000_0000;
      r.clipped = 1'b1;
    end else begin
      r.value   = v[DATA_W-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/tps_if.sv -----
// Request channel interfaces for sample input and solution output.
`default_nettype none
interface tps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] source_sample;
  logic               last_sample;
  modport source (output valid, source_sample, last_sample, input ready);
  modport sink   (input valid, source_sample, last_sample, output ready);
endinterface

interface tps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] solution_value;
  logic [6:0]         point_index;
  logic               saturated;
  logic               last_result;
  modport source (output valid, solution_value, point_index, saturated, last_result,
                  input ready);
  modport sink   (input valid, solution_value, point_index, saturated, last_result,
                  output ready);
endinterface
`default_nettype wire

// ----- design/tps_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module tps_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tps_pkg::DIV_W-1:0]  num,
  input  wire logic [tps_pkg::DATA_W-1:0] den,
  output logic                            done,
  output logic [tps_pkg::DIV_W-1:0]       quo
);
  import tps_pkg::*;

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DATA_W-1:0] den_r;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   trial;
  logic              fits;

  // Shift in next numerator bit, subtract when divisor fits
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DATA_W'(trial - {1'b0, den_r}) : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIVC_W'(DIV_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- design/tridiagonal_poisson_solver_top.sv -----
// Top level: Thomas-algorithm Poisson solver with sequencer and shared divider.
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        source_sample, last_sample
//  out_chan  out  valid/ready        solution_value, point_index, saturated, last_result
//  cfg_*     in   APB write/read     step_squared at byte address 0
//
// Sample: scale, two divisions (none for index 1), then store.
// Sweep per point: read, divider start, divider wait, emit, plus output wait.
// Reset (rst_n low, synchronous) clears control; stores need no clearing.
// in_chan ready only when idle; a stalled out_chan holds the sweep.
`default_nettype none
module tridiagonal_poisson_solver_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tps_in_if.sink           in_chan,
  tps_out_if.source        out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import tps_pkg::*;

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  tps_state_t state_r, state_nxt;

  logic [DATA_W-1:0] step_sq_r;
  logic [DATA_W-1:0] sample_r;
  logic              last_r;
  logic [DATA_W-1:0] d_r;
  logic [DATA_W-1:0] diag_new_r, rhs_new_r;
  logic [DATA_W-1:0] prev_diag_r, prev_rhs_r;
  logic [DATA_W-1:0] carry_r;
  logic [IW-1:0]     k_r, i_r;
  logic [DATA_W-1:0] rd_diag_r, rd_rhs_r;
  logic [DATA_W-1:0] diag_mem [MAX_POINTS];
  logic [DATA_W-1:0] rhs_mem  [MAX_POINTS];

  logic [DATA_W-1:0] out_val_r;
  logic [PIDX_W-1:0] out_idx_r;
  logic              out_sat_r, out_last_r;

  logic in_ready, out_valid, div_start, mem_we;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_STEP_SQ) ? step_sq_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_sq_r <= STEP_SQ_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == CFG_IDX_STEP_SQ) begin
      step_sq_r <= cfg_pwdata;
    end
  end

  // Scaled sample: round(source * step / 2^32)
  logic signed [65:0] prod;
  assign prod = 66'($signed(sample_r) * $signed({1'b0, step_sq_r})) + 66'sh8000_0000;

  // Divider operand selection and sign handling
  logic signed [DIV_W-1:0] div_snum;
  logic [DATA_W-1:0]       div_den, den_eff;
  logic [DATA_W-1:0]       den_src;
  logic                    div_neg, neg_r;
  logic [DIV_W-1:0]        div_mag, div_quo;
  logic                    div_done;
  logic signed [DATA_W:0]  back_sum;

  assign back_sum = $signed({rd_rhs_r[DATA_W-1], rd_rhs_r}) +
                    $signed({carry_r[DATA_W-1], carry_r});

  always_comb begin
    div_snum = '0;
    den_src  = prev_diag_r;
    case (state_r)
      ST_DIAG_GO: div_snum = $signed(ONE_SQ_Q48);
      ST_RHS_GO:  div_snum = $signed({{(DIV_W-DATA_W-24){prev_rhs_r[DATA_W-1]}},
                                      prev_rhs_r, 24'd0});
      ST_BACK_GO: begin
        div_snum = $signed({{(DIV_W-DATA_W-25){back_sum[DATA_W]}}, back_sum, 24'd0});
        den_src  = rd_diag_r;
      end
      default: div_snum = '0;
    endcase
  end

  assign den_eff = (den_src == '0) ? DATA_W'(1) : den_src;
  assign div_den = den_eff;
  assign div_neg = div_snum < 0;
  assign div_mag = (div_neg ? DIV_W'(-div_snum) : DIV_W'(div_snum)) +
                   DIV_W'(den_eff >> 1);

  tps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_mag),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [WIDE_W-1:0] q_signed;
  sat_t rhs_sat, x_sat;
  assign q_signed = neg_r ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  assign rhs_sat  = sat32(q_signed + WIDE_W'($signed(d_r)));
  assign x_sat    = sat32(q_signed);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_chan.valid) state_nxt = ST_SCALE;
      ST_SCALE:     state_nxt = (k_r == '0) ? ST_STORE : ST_DIAG_GO;
      ST_DIAG_GO:   state_nxt = ST_DIAG_WAIT;
      ST_DIAG_WAIT: if (div_done) state_nxt = ST_RHS_GO;
      ST_RHS_GO:    state_nxt = ST_RHS_WAIT;
      ST_RHS_WAIT:  if (div_done) state_nxt = ST_STORE;
      ST_STORE: begin
        if (last_r || k_r == IW'(MAX_POINTS-1)) state_nxt = ST_READ;
        else                                    state_nxt = ST_IDLE;
      end
      ST_READ:      state_nxt = ST_BACK_GO;
      ST_BACK_GO:   state_nxt = ST_BACK_WAIT;
      ST_BACK_WAIT: if (div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_chan.ready) state_nxt = (i_r == '0) ? ST_IDLE : ST_READ;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      ST_IDLE:    in_ready  = 1'b1;
      ST_DIAG_GO: div_start = 1'b1;
      ST_RHS_GO:  div_start = 1'b1;
      ST_BACK_GO: div_start = 1'b1;
      ST_STORE:   mem_we    = 1'b1;
      ST_EMIT:    out_valid = 1'b1;
      default:    in_ready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_STORE) begin
        if (state_nxt == ST_READ) begin
          i_r <= k_r;
          k_r <= '0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      if (state_r == ST_EMIT && out_chan.ready && i_r != '0) i_r <= i_r - 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      sample_r <= in_chan.source_sample;
      last_r   <= in_chan.last_sample;
    end
    if (div_start) neg_r <= div_neg;
    if (state_r == ST_SCALE) begin
      d_r        <= prod[63:32];
      diag_new_r <= TWO_Q24;
      rhs_new_r  <= prod[63:32];
    end
    if (state_r == ST_DIAG_WAIT && div_done) diag_new_r <= TWO_Q24 - div_quo[DATA_W-1:0];
    if (state_r == ST_RHS_WAIT && div_done)  rhs_new_r  <= rhs_sat.value;
    if (mem_we) begin
      prev_diag_r <= diag_new_r;
      prev_rhs_r  <= rhs_new_r;
      carry_r     <= '0;
    end
    if (state_r == ST_BACK_WAIT && div_done) begin
      carry_r    <= x_sat.value;
      out_val_r  <= x_sat.value;
      out_sat_r  <= x_sat.clipped;
      out_idx_r  <= PIDX_W'(i_r) + 1'b1;
      out_last_r <= (i_r == '0);
    end
  end

  // Stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      diag_mem[k_r] <= diag_new_r;
      rhs_mem[k_r]  <= rhs_new_r;
    end
    rd_diag_r <= diag_mem[i_r];
    rd_rhs_r  <= rhs_mem[i_r];
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid;
  assign out_chan.solution_value = out_val_r;
  assign out_chan.point_index    = out_idx_r;
  assign out_chan.saturated      = out_sat_r;
  assign out_chan.last_result    = out_last_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("accepted a sample while busy");
  a_last_is_index1: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.last_result |-> out_chan.point_index == PIDX_W'(1))
    else $error("last result not at index 1");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIAG_WAIT || state_r == ST_RHS_WAIT ||
                  state_r == ST_BACK_WAIT))
    else $error("divider finished outside a wait state");
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !in_chan.ready)
    else $error("input open during sweep");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the tridiagonal Poisson solver top level.
`default_nettype none
module tb_top;
  import tps_pkg::*;

  localparam int unsigned NPTS      = 64;
  localparam int unsigned IDLE_WAIT = 300;
  localparam int unsigned WDOG_MAX  = 6000;
  localparam longint      Q24_ONE   = 64'sd16777216;
  localparam longint      Q24_TWO   = 64'sd33554432;
  localparam logic [2:0]  ADDR_STEP_SQ = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED  = 3'd4;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         index;
    logic               sat;
    logic               last;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tps_in_if  in_if();
  tps_out_if out_if();

  tridiagonal_poisson_solver_top #(.MAX_POINTS(NPTS)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Solver shadow state
  logic [31:0] diag_shadow [NPTS];
  logic [31:0] rhs_shadow  [NPTS];
  int unsigned pts_held = 0;
  logic [31:0] step_sq  = STEP_SQ_RESET;
  solution_t   pending_solutions [$];

  int unsigned errors = 0;
  int unsigned sent   = 0;
  int unsigned rx_hold_ask = 0;
  bit          no_gaps = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.source_sample = '0;
    in_if.last_sample = 1'b0;
    out_if.ready = 1'b0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    if (den <= 0) den = 1;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip_q24(longint v, output logic clipped);
    clipped = 1'b1;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    clipped = 1'b0;
    return v;
  endfunction

  // Forward elimination of one sample; backward sweep when the problem closes
  task automatic eliminate_sample(logic signed [31:0] src, logic last);
    longint prod, scaled, dg, rh, pd, pr, sum, x, carry;
    logic c;
    int k;
    solution_t sol;
    prod = longint'(src) * longint'({32'b0, step_sq});
    scaled = (prod + 64'sd2147483648) >>> 32;
    k = pts_held;
    if (k >= NPTS) k = NPTS - 1;
    if (k == 0) begin
      dg = Q24_TWO;
      rh = scaled;
    end else begin
      pd = longint'({32'b0, diag_shadow[k-1]});
      pr = longint'($signed(rhs_shadow[k-1]));
      dg = Q24_TWO - round_div(Q24_ONE * Q24_ONE, pd);
      rh = clip_q24(scaled + round_div(pr * Q24_ONE, pd), c);
    end
    diag_shadow[k] = dg[31:0];
    rhs_shadow[k] = rh[31:0];
    pts_held = k + 1;
    if (!last && pts_held < NPTS) return;
    carry = 0;
    for (int i = pts_held - 1; i >= 0; i--) begin
      sum = longint'($signed(rhs_shadow[i])) + carry;
      x = clip_q24(round_div(sum * Q24_ONE, longint'({32'b0, diag_shadow[i]})), c);
      carry = x;
      sol.value = x[31:0];
      sol.index = 7'(i + 1);
      sol.sat = c;
      sol.last = (i == 0);
      pending_solutions.push_back(sol);
    end
    pts_held = 0;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 70);
  endfunction

  // Offer one sample and hold it until accepted
  task automatic send_sample(logic signed [31:0] src, logic last);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.source_sample <= src;
    in_if.last_sample <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    eliminate_sample(src, last);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every expected solution arrived, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_STEP_SQ) step_sq = data;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    if (r < 85) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $signed($urandom_range(0, 64)) - 32'sd32;
  endfunction

  // One well-formed problem of the given length
  task automatic send_problem(int unsigned len, bit mark_last);
    for (int unsigned i = 0; i < len; i++)
      send_sample(rand_sample(), mark_last && (i == len - 1));
  endtask

  task automatic test_directed();
    cfg_write(ADDR_STEP_SQ, 32'hFFFF_FFFF);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b1);
    // saturation in forward and backward passes
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'shAAAA_AAAA, 1'b0);
    // register change in the middle of a problem
    drain();
    cfg_write(ADDR_STEP_SQ, 32'h5555_5555);
    send_sample(32'sh5555_5555, 1'b1);
    drain();
    // unknown register index must be ignored
    cfg_write(ADDR_UNUSED, 32'h1234_5678);
    cfg_write(ADDR_STEP_SQ, 32'h0000_0000);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh0000_0001, 1'b1);
    drain();
    cfg_write(ADDR_STEP_SQ, 32'h0000_0001);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b1);
    drain();
    cfg_write(ADDR_STEP_SQ, STEP_SQ_RESET);
    send_sample(32'sh0100_0000, 1'b0);
    send_sample(32'sh0100_0000, 1'b0);
    send_sample(32'shFF00_0000, 1'b1);
    drain();
  endtask

  // Full-capacity problem closes without a last marker
  task automatic test_capacity();
    cfg_write(ADDR_STEP_SQ, 32'h0400_0000);
    send_problem(NPTS, 1'b0);
    drain();
  endtask

  // Receiver holds off while samples keep coming, then the sender waits
  task automatic test_backpressure();
    cfg_write(ADDR_STEP_SQ, 32'h1000_0000);
    rx_hold_ask = 700;
    no_gaps = 1;
    send_problem(3, 1'b1);
    send_problem(4, 1'b1);
    send_problem(2, 1'b1);
    no_gaps = 0;
    drain();
  endtask

  task automatic test_random();
    int unsigned r, len, phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: cfg_write(ADDR_STEP_SQ, STEP_SQ_RESET);
        1: cfg_write(ADDR_STEP_SQ, 32'hFFFF_FFFF);
        2: cfg_write(ADDR_STEP_SQ, $urandom);
        default: cfg_write(ADDR_STEP_SQ, $urandom_range(0, 32'h0100_0000));
      endcase
      no_gaps = (ph == 2);
      phase_end = sent + 32;
      while (sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 75) len = $urandom_range(1, 8);
        else if (r < 97) len = $urandom_range(9, 20);
        else len = NPTS;
        send_problem(len, 1'b1);
      end
      no_gaps = 0;
      drain();
    end
  endtask

  // Result receiver: random stalls, plus a long hold-off on request
  int unsigned rx_wait = 0;
  always @(posedge clk) begin
    if (rx_hold_ask != 0) begin
      rx_wait = rx_hold_ask;
      rx_hold_ask = 0;
    end
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_if.ready <= 1'b0;
      rx_wait--;
    end else if (no_gaps) begin
      out_if.ready <= 1'b1;
    end else begin
      r_gap: begin
        int unsigned g;
        g = pick_gap();
        if (g > 1) rx_wait = g - 1;
        out_if.ready <= (g == 0);
      end
    end
  end

  // Check each accepted solution against the oldest expectation
  always @(posedge clk) begin
    solution_t exp_sol;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_solutions.size() == 0) begin
        $error("unexpected solution: value %h index %0d", out_if.solution_value,
               out_if.point_index);
        errors++;
      end else begin
        exp_sol = pending_solutions.pop_front();
        if (out_if.solution_value !== exp_sol.value) begin
          $error("solution_value: expected %h, got %h", exp_sol.value, out_if.solution_value);
          errors++;
        end
        if (out_if.point_index !== exp_sol.index) begin
          $error("point_index: expected %0d, got %0d", exp_sol.index, out_if.point_index);
          errors++;
        end
        if (out_if.saturated !== exp_sol.sat) begin
          $error("saturated: expected %b, got %b", exp_sol.sat, out_if.saturated);
          errors++;
        end
        if (out_if.last_result !== exp_sol.last) begin
          $error("last_result: expected %b, got %b", exp_sol.last, out_if.last_result);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && pending_solutions.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
